>>> src/gmbe_pkg.sv
// Shared types and constants for the Gilbert-Moore byte encoder.
`default_nettype none
package gmbe_pkg;
  localparam int unsigned SymbolCount = 256;
  localparam int unsigned CountBits   = 24;
  localparam int unsigned CodeBits    = 25;
  localparam int unsigned LenBits     = 5;
  localparam int unsigned PresBits    = 9;
  localparam logic [7:0]  OrderFlip   = 8'h80;

  typedef enum logic [1:0] {
    KIND_COUNT  = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_ENCODE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ABSENT   = 2'd1,
    ST_NOTBUILT = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE, S_ENC, S_CNT, S_BREAD, S_BLEN, S_BDIV, S_BWR
  } eng_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] symbol;
  } cmd_t;

  typedef struct packed {
    logic [CodeBits-1:0] codeword;
    logic [LenBits-1:0]  code_length;
    status_e             status;
    logic [PresBits-1:0] distinct_symbols;
  } result_t;
endpackage
`default_nettype wire

>>> src/gilbert_moore_byte_encoder.sv
// Top level of the Gilbert-Moore byte encoder.
// Usage:
//  - Commands enter through a queue port: push with kind_i/symbol_i, held off by full.
//    kind: count byte, build table, encode byte, clear statistics.
//  - Results leave through a queue port: while empty is low the oldest result
//    is on codeword_o/code_length_o/status_o/distinct_symbols_o; pop takes it.
//  - Build and encode give one result transaction; count and clear give none.
//  - A four-entry command queue decouples the front from the back engine;
//    a pushed transaction is registered in it before the engine can take it.
// Sequence:
//  - Count: count memory read, then write back.
//  - Encode: table memory read, then result register.
//  - Build: 256 slots, each a count read, then for a present symbol a serial
//    length search and a long division, then a table write.
// Reset clears the count valid bits, totals and flags; the code table is
// not cleared and is read only after a build. If the result is not
// popped the engine holds and commands collect in the queue until full.
`default_nettype none
module gilbert_moore_byte_encoder #(
  parameter int unsigned SYMBOL_COUNT = gmbe_pkg::SymbolCount,
  parameter int unsigned COUNT_BITS   = gmbe_pkg::CountBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  symbol_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [24:0]      codeword_o,
  output logic [4:0]       code_length_o,
  output logic [1:0]       status_o,
  output logic [8:0]       distinct_symbols_o
);
  gmbe_pkg::cmd_t    in_cmd, q_cmd;
  gmbe_pkg::result_t res;
  logic q_empty, take, res_v;

  assign in_cmd.kind   = gmbe_pkg::kind_e'(kind_i);
  assign in_cmd.symbol = symbol_i;

  gmbe_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(push), .wdata_i(in_cmd), .full_o(full),
    .rd_i(take), .rdata_o(q_cmd), .empty_o(q_empty)
  );

  gmbe_engine #(.SYMBOL_COUNT(SYMBOL_COUNT), .COUNT_BITS(COUNT_BITS)) u_eng (
    .clk_i, .rst_ni, .cmd_i(q_cmd), .cmd_valid_i(!q_empty), .cmd_take_o(take),
    .res_o(res), .res_valid_o(res_v), .res_pop_i(pop)
  );

  assign empty              = !res_v;
  assign codeword_o         = res.codeword;
  assign code_length_o      = res.code_length;
  assign status_o           = res.status;
  assign distinct_symbols_o = res.distinct_symbols;
endmodule
`default_nettype wire

>>> src/gmbe_cmd_fifo.sv
// Short command queue between the front and the back of the encoder.
`default_nettype none
module gmbe_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_i,
  input  gmbe_pkg::cmd_t     wdata_i,
  output logic               full_o,
  input  wire logic          rd_i,
  output gmbe_pkg::cmd_t     rdata_o,
  output logic               empty_o
);
  gmbe_pkg::cmd_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= wp_q + 2'd1;
      if (rd_i && !empty_o) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'((wr_i && !full_o)) - 3'((rd_i && !empty_o));
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !empty_o)
    else $error("fifo full and empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_i && !empty_o && !(wr_i && !full_o)) |=> !full_o)
    else $error("fifo full after pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("fifo count out of range");
endmodule
`default_nettype wire

>>> src/gmbe_engine.sv
// Back end: counting, table build sequencer, encode lookup and result register.
`default_nettype none
module gmbe_engine #(
  parameter int unsigned SYMBOL_COUNT = gmbe_pkg::SymbolCount,
  parameter int unsigned COUNT_BITS   = gmbe_pkg::CountBits
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  gmbe_pkg::cmd_t     cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_take_o,
  output gmbe_pkg::result_t  res_o,
  output logic               res_valid_o,
  input  wire logic          res_pop_i
);
  localparam int unsigned CB = gmbe_pkg::CodeBits;
  localparam int unsigned DW = COUNT_BITS + 2;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  gmbe_pkg::eng_state_e st_q, st_d;
  logic [COUNT_BITS-1:0] cnt_mem [256];
  logic [gmbe_pkg::LenBits-1:0] len_mem [256];
  logic [CB-1:0] cw_mem [256];
  logic [255:0] cvalid_q;

  logic [COUNT_BITS-1:0] total_q, c_q, rd_q, cum_q;
  logic [gmbe_pkg::PresBits-1:0] pres_q;
  logic ready_q, ovf_q;
  logic [8:0] idx_q;
  logic [7:0] sym_q;
  logic [5:0] k_q, b_q;
  logic [4:0] len_q;
  logic [DW-1:0] rem_q;
  logic [CB-1:0] word_q;
  logic [gmbe_pkg::LenBits-1:0] lrd_q;
  logic [CB-1:0] wrd_q;
  logic res_v_q;
  gmbe_pkg::result_t res_q;

  logic [COUNT_BITS-1:0] rcnt;
  logic [DW-1:0] den, num, sh;
  logic [COUNT_BITS+40:0] ck;
  logic [COUNT_BITS:0] cum_sum;
  logic [7:0] csym;

  assign rcnt = cvalid_q[sym_q] ? rd_q : '0;
  assign den  = {1'b0, total_q, 1'b0};
  assign csym = cmd_i.symbol;
  assign ck   = {{41{1'b0}}, rcnt} << k_q;
  assign cum_sum = {1'b0, cum_q} + {1'b0, c_q};
  assign res_o = res_q;
  assign res_valid_o = res_v_q;
  assign cmd_take_o = (st_q == gmbe_pkg::S_IDLE) && cmd_valid_i && !res_v_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      gmbe_pkg::S_IDLE: if (cmd_take_o) begin
        case (cmd_i.kind)
          gmbe_pkg::KIND_COUNT:  st_d = (32'(csym) < SYMBOL_COUNT) ? gmbe_pkg::S_CNT
                                                                  : gmbe_pkg::S_IDLE;
          gmbe_pkg::KIND_ENCODE: st_d = gmbe_pkg::S_ENC;
          gmbe_pkg::KIND_BUILD:  st_d = gmbe_pkg::S_BREAD;
          default:               st_d = gmbe_pkg::S_IDLE;
        endcase
      end
      gmbe_pkg::S_ENC:   st_d = gmbe_pkg::S_IDLE;
      gmbe_pkg::S_CNT:   st_d = gmbe_pkg::S_IDLE;
      gmbe_pkg::S_BREAD: st_d = gmbe_pkg::S_BLEN;
      gmbe_pkg::S_BLEN:  if (rcnt == '0 || total_q == '0 || 32'(sym_q) >= SYMBOL_COUNT)
                           st_d = gmbe_pkg::S_BWR;
                         else if (k_q == 6'd40 ||
                                  ck[COUNT_BITS+40:0] >= (COUNT_BITS+41)'(total_q))
                           st_d = gmbe_pkg::S_BDIV;
      gmbe_pkg::S_BDIV:  if (b_q == 6'(len_q)) st_d = gmbe_pkg::S_BWR;
      gmbe_pkg::S_BWR:   st_d = (idx_q == 9'd255) ? gmbe_pkg::S_IDLE : gmbe_pkg::S_BREAD;
      default:           st_d = gmbe_pkg::S_IDLE;
    endcase
  end

  // Fraction remainder seed: (2*cum + c) mod 2T. cum is kept modulo T and
  // c never exceeds T, so the value is below 4T and two subtracts suffice.
  always_comb begin
    num = {1'b0, cum_q, 1'b0} + DW'(c_q);
    if (num >= den) num = num - den;
    if (num >= den) num = num - den;
    sh = {rem_q[DW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (st_q == gmbe_pkg::S_BWR) begin
      sym_q <= (idx_q[7:0] + 8'd1) ^ gmbe_pkg::OrderFlip;
    end else if (st_q == gmbe_pkg::S_IDLE && cmd_take_o) begin
      sym_q <= (cmd_i.kind == gmbe_pkg::KIND_BUILD) ? gmbe_pkg::OrderFlip : csym;
    end
    rd_q  <= cnt_mem[(st_q == gmbe_pkg::S_IDLE) ? csym : sym_q];
    lrd_q <= len_mem[csym];
    wrd_q <= cw_mem[csym];
    // saturated count is left as it is
    if (st_q == gmbe_pkg::S_CNT && rcnt != CMAX) cnt_mem[sym_q] <= rcnt + COUNT_BITS'(1);
    if (st_q == gmbe_pkg::S_BWR) begin
      len_mem[sym_q] <= len_q;
      cw_mem[sym_q]  <= (rcnt == '0 || total_q == '0 || 32'(sym_q) >= SYMBOL_COUNT) ?
                        '0 : word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= gmbe_pkg::S_IDLE; cvalid_q <= '0; total_q <= '0; pres_q <= '0;
      ready_q <= 1'b0; ovf_q <= 1'b0; idx_q <= '0; res_v_q <= 1'b0;
      k_q <= '0; b_q <= '0; len_q <= '0; rem_q <= '0; word_q <= '0;
      cum_q <= '0; c_q <= '0; res_q <= '0;
    end else begin
      st_q <= st_d;
      if (res_v_q && res_pop_i) res_v_q <= 1'b0;
      case (st_q)
        gmbe_pkg::S_IDLE: if (cmd_take_o) begin
          case (cmd_i.kind)
            gmbe_pkg::KIND_COUNT: if (32'(csym) < SYMBOL_COUNT) begin
              if (total_q == CMAX) ovf_q <= 1'b1;
              else total_q <= total_q + COUNT_BITS'(1);
            end
            gmbe_pkg::KIND_CLEAR: begin
              cvalid_q <= '0; total_q <= '0; pres_q <= '0;
              ovf_q <= 1'b0; ready_q <= 1'b0;
            end
            gmbe_pkg::KIND_BUILD: begin
              idx_q <= '0; cum_q <= '0; pres_q <= '0;
            end
            default: ;
          endcase
        end
        gmbe_pkg::S_CNT: begin
          // count write-back: rd_q holds the old count
          if (rcnt == CMAX) ovf_q <= 1'b1;
          else cvalid_q[sym_q] <= 1'b1;
        end
        gmbe_pkg::S_ENC: begin
          res_v_q <= 1'b1;
          res_q.distinct_symbols <= pres_q;
          res_q.codeword <= '0; res_q.code_length <= '0;
          if (!ready_q) res_q.status <= gmbe_pkg::ST_NOTBUILT;
          else if (lrd_q == '0) res_q.status <= gmbe_pkg::ST_ABSENT;
          else begin
            res_q.codeword <= wrd_q; res_q.code_length <= lrd_q;
            res_q.status <= ovf_q ? gmbe_pkg::ST_OVERFLOW : gmbe_pkg::ST_OK;
          end
        end
        gmbe_pkg::S_BREAD: begin k_q <= '0; end
        gmbe_pkg::S_BLEN: begin
          c_q <= rcnt;
          if (st_d == gmbe_pkg::S_BLEN) begin
            k_q <= k_q + 6'd1;
          end else if (st_d == gmbe_pkg::S_BDIV) begin
            len_q <= (k_q >= 6'd25) ? 5'd25 : 5'(k_q + 6'd1);
            b_q <= '0; word_q <= '0;
          end else len_q <= '0;
        end
        gmbe_pkg::S_BDIV: begin
          if (b_q == '0) begin
            // first step seeds remainder and does bit one
            rem_q  <= ({num[DW-2:0],1'b0} >= den) ? {num[DW-2:0],1'b0} - den
                                                   : {num[DW-2:0],1'b0};
            word_q <= {word_q[CB-2:0], ({num[DW-2:0],1'b0} >= den)};
          end else if (b_q != 6'(len_q)) begin
            rem_q  <= (sh >= den) ? sh - den : sh;
            word_q <= {word_q[CB-2:0], (sh >= den)};
          end
          if (b_q != 6'(len_q)) b_q <= b_q + 6'd1;
        end
        gmbe_pkg::S_BWR: begin
          if (len_q != '0) begin
            // running cumulative count, kept modulo the total
            cum_q <= (cum_sum >= {1'b0, total_q}) ? COUNT_BITS'(cum_sum - {1'b0, total_q})
                                                  : cum_sum[COUNT_BITS-1:0];
            pres_q <= pres_q + 9'd1;
          end
          idx_q <= idx_q + 9'd1;
          if (idx_q == 9'd255) begin
            ready_q <= 1'b1; res_v_q <= 1'b1;
            res_q.codeword <= '0; res_q.code_length <= '0;
            res_q.status <= ovf_q ? gmbe_pkg::ST_OVERFLOW : gmbe_pkg::ST_OK;
            res_q.distinct_symbols <= pres_q + 9'(len_q != '0);
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && !res_pop_i |=> res_v_q)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> res_q.code_length <= 5'd25)
    else $error("length too long");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> st_q == gmbe_pkg::S_IDLE)
    else $error("take while busy");
endmodule
`default_nettype wire
